FILE: hw/rtl/esctlm_pkg.sv
// Shared types, constants and the CRC-8 step function for the telemetry frame decoder.
package esctlm_pkg;

    localparam int FRAME_BYTES  = 10;
    localparam int COUNTER_BITS = 32;
    localparam int FILL_BITS    = $clog2(FRAME_BYTES + 1);
    localparam int STORE_BYTES  = FRAME_BYTES - 1;
    localparam int ERPM_BITS    = 23;
    localparam int VIEW_BITS    = 32;

    localparam logic [7:0] CRC_POLY = 8'h07;
    localparam logic [ERPM_BITS-1:0] ERPM_SCALE = ERPM_BITS'(100);
    localparam logic [FILL_BITS-1:0] FILL_IDLE = FILL_BITS'(FRAME_BYTES);
    localparam logic [FILL_BITS-1:0] FILL_LAST = FILL_BITS'(FRAME_BYTES - 1);
    localparam logic [VIEW_BITS-1:0] CNT_VIEW_MASK =
        VIEW_BITS'((65'd1 << COUNTER_BITS) - 65'd1);

    typedef enum logic [2:0] {
        ST_STORED  = 3'd0,
        ST_GOOD    = 3'd1,
        ST_CRC_ERR = 3'd2,
        ST_OVERRUN = 3'd3,
        ST_ARMED   = 3'd4
    } status_t;

    typedef struct packed {
        logic       command;
        logic [7:0] data_byte;
    } item_t;

    typedef struct packed {
        status_t                status;
        logic [7:0]             temperature_c;
        logic [15:0]            voltage_centivolts;
        logic [15:0]            current_centiamps;
        logic [15:0]            consumption_mah;
        logic [ERPM_BITS-1:0]   electrical_rpm;
        logic [VIEW_BITS-1:0]   good_frames;
        logic [VIEW_BITS-1:0]   bad_frames;
        logic [VIEW_BITS-1:0]   overrun_bytes;
    } result_t;

    typedef struct packed {
        logic advance;
    } pipe_ctrl_t;

    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int k = 0; k < 8; k++)
        begin
            if (c[7])
            begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

FILE: hw/rtl/esc_telemetry_frame_decoder_core.sv
// Top level of the telemetry frame decoder with CRC-8 check.
// Each request is either an arm command or one telemetry byte. A request is taken every cycle
// when the result side keeps up. It is held in the input register, where the frame logic works
// on it, and its result is then loaded into the result register, which drives the outputs. The
// CRC-8 update, byte store and counter increment for a byte are made at the same edge that loads
// that result. A stall on the result side holds the request in the input register and stalls the
// input once that register is full. After reset the block is idle and counts data bytes as
// overruns until the first arm. A frame is ten bytes; the tenth is compared with the running CRC
// of the first nine, and the decoded fields are nonzero only on a good frame. Counters wrap.
module esc_telemetry_frame_decoder_core
    import esctlm_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_stall,
    input  logic                 command,
    input  logic [7:0]           data_byte,
    output logic                 res_valid,
    input  logic                 res_stall,
    output logic [2:0]           status,
    output logic [7:0]           temperature_c,
    output logic [15:0]          voltage_centivolts,
    output logic [15:0]          current_centiamps,
    output logic [15:0]          consumption_mah,
    output logic [ERPM_BITS-1:0] electrical_rpm,
    output logic [VIEW_BITS-1:0] good_frames,
    output logic [VIEW_BITS-1:0] bad_frames,
    output logic [VIEW_BITS-1:0] overrun_bytes
);

    item_t      req_item;
    item_t      item;
    logic       item_valid;
    pipe_ctrl_t ctrl;
    result_t    result_next;
    result_t    result;

    assign req_item.command   = command;
    assign req_item.data_byte = data_byte;

    esctlm_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .req_item   (req_item),
        .ctrl       (ctrl),
        .item_valid (item_valid),
        .item       (item)
    );

    esctlm_frame_core u_frame_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (ctrl),
        .item   (item),
        .result (result_next)
    );

    esctlm_out_stage u_out_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .result_in  (result_next),
        .ctrl       (ctrl),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .result_out (result)
    );

    assign status             = result.status;
    assign temperature_c      = result.temperature_c;
    assign voltage_centivolts = result.voltage_centivolts;
    assign current_centiamps  = result.current_centiamps;
    assign consumption_mah    = result.consumption_mah;
    assign electrical_rpm     = result.electrical_rpm;
    assign good_frames        = result.good_frames;
    assign bad_frames         = result.bad_frames;
    assign overrun_bytes      = result.overrun_bytes;

endmodule

FILE: hw/rtl/esctlm_in_stage.sv
// Input register stage that holds one request ahead of the frame logic.
module esctlm_in_stage
    import esctlm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    output logic       req_stall,
    input  item_t      req_item,
    input  pipe_ctrl_t ctrl,
    output logic       item_valid,
    output item_t      item
);

    logic  item_valid_reg;
    logic  item_valid_next;
    item_t item_reg;
    logic  load;

    assign load            = !item_valid_reg || ctrl.advance;
    assign req_stall       = !load;
    assign item_valid_next = load ? req_valid : item_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && req_valid)
        begin
            item_reg <= req_item;
        end
    end

    assign item_valid = item_valid_reg;
    assign item       = item_reg;

endmodule

FILE: hw/rtl/esctlm_frame_core.sv
// Frame state, running CRC, counters and field decode for one request per cycle while the pipeline advances.
module esctlm_frame_core
    import esctlm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  pipe_ctrl_t ctrl,
    input  item_t      item,
    output result_t    result
);

    logic [7:0]              store_reg [STORE_BYTES];
    logic [FILL_BITS-1:0]    fill_reg;
    logic [FILL_BITS-1:0]    fill_next;
    logic [7:0]              crc_reg;
    logic [7:0]              crc_next;
    logic [COUNTER_BITS-1:0] good_reg;
    logic [COUNTER_BITS-1:0] good_next;
    logic [COUNTER_BITS-1:0] bad_reg;
    logic [COUNTER_BITS-1:0] bad_next;
    logic [COUNTER_BITS-1:0] overrun_reg;
    logic [COUNTER_BITS-1:0] overrun_next;
    logic                    store_we;
    logic [15:0]             rpm_raw;

    assign rpm_raw = {store_reg[7], store_reg[8]};

    always_comb
    begin
        fill_next    = fill_reg;
        crc_next     = crc_reg;
        good_next    = good_reg;
        bad_next     = bad_reg;
        overrun_next = overrun_reg;
        store_we     = 1'b0;
        result       = '0;

        if (item.command)
        begin
            fill_next     = '0;
            crc_next      = '0;
            result.status = ST_ARMED;
        end
        else if (fill_reg >= FILL_IDLE)
        begin
            overrun_next  = overrun_reg + 1'b1;
            result.status = ST_OVERRUN;
        end
        else if (fill_reg != FILL_LAST)
        begin
            store_we      = 1'b1;
            crc_next      = crc8_step(crc_reg, item.data_byte);
            fill_next     = fill_reg + 1'b1;
            result.status = ST_STORED;
        end
        else
        begin
            fill_next = '0;
            crc_next  = '0;
            if (crc_reg == item.data_byte)
            begin
                good_next                 = good_reg + 1'b1;
                result.status             = ST_GOOD;
                result.temperature_c      = store_reg[0];
                result.voltage_centivolts = {store_reg[1], store_reg[2]};
                result.current_centiamps  = {store_reg[3], store_reg[4]};
                result.consumption_mah    = {store_reg[5], store_reg[6]};
                result.electrical_rpm     = ERPM_BITS'(rpm_raw) * ERPM_SCALE;
            end
            else
            begin
                bad_next      = bad_reg + 1'b1;
                result.status = ST_CRC_ERR;
            end
        end

        result.good_frames   = VIEW_BITS'(good_next);
        result.bad_frames    = VIEW_BITS'(bad_next);
        result.overrun_bytes = VIEW_BITS'(overrun_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg    <= FILL_IDLE;
            crc_reg     <= '0;
            good_reg    <= '0;
            bad_reg     <= '0;
            overrun_reg <= '0;
        end
        else if (ctrl.advance)
        begin
            fill_reg    <= fill_next;
            crc_reg     <= crc_next;
            good_reg    <= good_next;
            bad_reg     <= bad_next;
            overrun_reg <= overrun_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.advance && store_we)
        begin
            store_reg[fill_reg[FILL_BITS-1:0]] <= item.data_byte;
        end
    end

endmodule

FILE: hw/rtl/esctlm_out_stage.sv
// Result register and the advance control shared by the pipeline.
module esctlm_out_stage
    import esctlm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    input  result_t    result_in,
    output pipe_ctrl_t ctrl,
    output logic       res_valid,
    input  logic       res_stall,
    output result_t    result_out
);

    logic    res_valid_reg;
    logic    res_valid_next;
    result_t result_reg;
    logic    slot_free;

    assign slot_free      = !res_valid_reg || !res_stall;
    assign ctrl.advance   = item_valid && slot_free;
    assign res_valid_next = slot_free ? item_valid : res_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.advance)
        begin
            result_reg <= result_in;
        end
    end

    assign res_valid  = res_valid_reg;
    assign result_out = result_reg;

endmodule

FILE: hw/rtl/esctlm_checker.sv
// Port-level checks for the telemetry frame decoder and their binding to the top level.
module esctlm_checker
    import esctlm_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 req_stall,
    input logic                 res_valid,
    input logic                 res_stall,
    input logic [2:0]           status,
    input logic [7:0]           temperature_c,
    input logic [15:0]          voltage_centivolts,
    input logic [15:0]          current_centiamps,
    input logic [15:0]          consumption_mah,
    input logic [ERPM_BITS-1:0] electrical_rpm,
    input logic [VIEW_BITS-1:0] good_frames,
    input logic [VIEW_BITS-1:0] overrun_bytes
);

    a_stalled_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(status) && $stable(good_frames))
        else $error("Stalled result changed.");

    a_empty_output_accepts: assert property (@(posedge clk) disable iff (!rst_n)
        !res_valid |-> !req_stall)
        else $error("Request stalled while the result register was empty.");

    a_decoded_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && status != ST_GOOD |-> temperature_c == '0 && voltage_centivolts == '0
            && current_centiamps == '0 && consumption_mah == '0 && electrical_rpm == '0)
        else $error("Decoded fields nonzero without a good frame.");

    a_overrun_counts: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_stall) ##1 (res_valid && status == ST_OVERRUN)
            |-> overrun_bytes == (($past(overrun_bytes) + 1'b1) & CNT_VIEW_MASK))
        else $error("Overrun count did not advance by one.");

    a_good_counts: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_stall) ##1 (res_valid && status == ST_GOOD)
            |-> good_frames == (($past(good_frames) + 1'b1) & CNT_VIEW_MASK))
        else $error("Good frame count did not advance by one.");

endmodule

bind esc_telemetry_frame_decoder_core esctlm_checker u_esctlm_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .req_stall          (req_stall),
    .res_valid          (res_valid),
    .res_stall          (res_stall),
    .status             (status),
    .temperature_c      (temperature_c),
    .voltage_centivolts (voltage_centivolts),
    .current_centiamps  (current_centiamps),
    .consumption_mah    (consumption_mah),
    .electrical_rpm     (electrical_rpm),
    .good_frames        (good_frames),
    .overrun_bytes      (overrun_bytes)
);
